@@ sv/mecd_pkg.sv @@
// ----------------------------------------------------------------------------
// mecd_pkg
// Shared types and constants of the minimum-eigenvalue corner detector.
// ----------------------------------------------------------------------------
`default_nettype none

package mecd_pkg;

  localparam int unsigned GradW   = 8;
  localparam int unsigned PixW    = 2 * GradW;
  localparam int unsigned RowW    = 12;
  localparam int unsigned ColW    = 10;
  localparam int unsigned StrW    = 20;
  localparam int unsigned SumW    = 20;
  localparam int unsigned SW      = SumW + 1;
  localparam int unsigned DW      = 2 * SW;
  localparam int unsigned RootW   = SW;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned CfgWidthW  = 11;
  localparam int unsigned CfgHeightW = 13;
  localparam int unsigned MaxHeight  = 4096;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH     = 2'd0,
    CFG_HEIGHT    = 2'd1,
    CFG_THRESHOLD = 2'd2,
    CFG_SPARE     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MUL,
    ST_CMP,
    ST_SQRT,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

@@ sv/min_eigen_corner_detector.sv @@
// ----------------------------------------------------------------------------
// min_eigen_corner_detector
// Shi-Tomasi corner detector over a 3x3 window of gradient words.
//
//   channel   dir  handshake             payload
//   s_axis    in   tvalid/tready         tdata: grad_x[7:0], grad_y[15:8]
//   m_axis    out  tvalid/tready         tdata: row[11:0], col[21:12], str[41:22]
//   cfg       in   cfg_valid/cfg_ready   cfg_index (register), cfg_data
//
// One word at a time: accept, then a line-store read-modify-write;
// a window inside the frame adds the column sums, a multiply and a compare;
// a corner adds 21 square-root steps, a rounding step and an output step that
// waits for a free m_axis register. After reset a clearing pass zeroes all
// MAX_WIDTH line-store entries; s_axis_tready stays low during it. A stalled
// m_axis word holds the result while the next input word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module min_eigen_corner_detector #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned WINDOW_SIZE = 3
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [mecd_pkg::InDataW-1:0]    s_axis_tdata,  // grad_x, grad_y
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [mecd_pkg::OutDataW-1:0]   m_axis_tdata,  // row, col, strength, pad
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mecd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [mecd_pkg::CfgDataW-1:0]   cfg_data_i
);

  import mecd_pkg::*;

  localparam int unsigned Lines = WINDOW_SIZE - 1;
  localparam int unsigned NWin  = WINDOW_SIZE * WINDOW_SIZE;
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = CW + 1;
  localparam int unsigned LsW   = PixW * Lines;

  // configuration
  logic [CfgWidthW-1:0]  cfg_w_q;
  logic [CfgHeightW-1:0] cfg_h_q;
  logic [StrW-1:0]       thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CfgWidthW'(640);
      cfg_h_q <= CfgHeightW'(480);
      thr_q   <= StrW'(1000);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:     cfg_w_q <= cfg_data_i[CfgWidthW-1:0];
        CFG_HEIGHT:    cfg_h_q <= cfg_data_i[CfgHeightW-1:0];
        CFG_THRESHOLD: thr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [WW-1:0]         w_cl;
  logic [CfgHeightW-1:0] h_cl;

  always_comb begin
    if (cfg_w_q < CfgWidthW'(4)) begin
      w_cl = WW'(4);
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      w_cl = WW'(MAX_WIDTH);
    end else begin
      w_cl = WW'(32'(cfg_w_q));
    end
    if (cfg_h_q < CfgHeightW'(4)) begin
      h_cl = CfgHeightW'(4);
    end else if (32'(cfg_h_q) > MaxHeight) begin
      h_cl = CfgHeightW'(MaxHeight);
    end else begin
      h_cl = cfg_h_q;
    end
  end

  // control and datapath registers
  state_e state_q, state_d;
  logic [WW-1:0]    clr_q;
  logic             clr_busy;
  logic [CW-1:0]    col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [CW-1:0]    cur_col_q;
  logic [RowW-1:0]  cur_row_q;
  logic [PixW-1:0]  px_q;
  logic [PixW-1:0]  win_q [NWin];
  logic [1:0]       sum_k_q;
  logic [SumW-1:0]  a_q, b_q, c_q;
  logic [DW-1:0]    dsq_q, bsq_q, smsq_q, d_q;
  logic [SW-1:0]    s_q;
  logic             spos_q;
  logic [RootW-1:0] r_q;
  logic [4:0]       bit_q;
  logic [StrW-1:0]  str_q;
  logic             out_vld_q;
  logic [RowW-1:0]  out_row_q;
  logic [ColW-1:0]  out_col_q;
  logic [StrW-1:0]  out_str_q;

  logic             in_acc;
  logic [LsW-1:0]   ls_rdata;
  logic             ls_we;
  logic [CW-1:0]    ls_waddr;
  logic [LsW-1:0]   ls_wdata;
  logic             eligible;
  logic             out_free;

  assign clr_busy      = (32'(clr_q) < MAX_WIDTH);
  assign s_axis_tready = (state_q == ST_IDLE) && !clr_busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  mecd_ram #(
    .WIDTH (LsW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .waddr_i (ls_waddr),
    .wdata_i (ls_wdata),
    .raddr_i (col_q),
    .rdata_o (ls_rdata)
  );

  always_comb begin
    if (clr_busy) begin
      ls_we    = 1'b1;
      ls_waddr = clr_q[CW-1:0];
      ls_wdata = '0;
    end else begin
      ls_we    = (state_q == ST_READ);
      ls_waddr = cur_col_q;
      ls_wdata = {px_q, ls_rdata[LsW-1 -: PixW]};
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (32'(col_q) + 1 >= 32'(w_cl)) begin
      col_d = '0;
      row_d = (32'(row_q) + 1 >= 32'(h_cl)) ? '0 : row_q + RowW'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  assign eligible = (32'(cur_row_q) >= Lines) && (32'(cur_col_q) >= Lines) &&
                    (32'(cur_row_q) - Lines < 32'(h_cl) - WINDOW_SIZE) &&
                    (32'(cur_col_q) - Lines < 32'(w_cl) - WINDOW_SIZE);

  // column sums
  logic [SumW-1:0] pa, pb, pc;
  always_comb begin
    logic [GradW-1:0] gx, gy;
    pa = '0;
    pb = '0;
    pc = '0;
    for (int k = 0; k < WINDOW_SIZE; k++) begin
      gx = win_q[k * WINDOW_SIZE + 32'(sum_k_q)][PixW-1:GradW];
      gy = win_q[k * WINDOW_SIZE + 32'(sum_k_q)][GradW-1:0];
      pa = pa + SumW'(gx) * SumW'(gx);
      pb = pb + SumW'(gx) * SumW'(gy);
      pc = pc + SumW'(gy) * SumW'(gy);
    end
  end

  // eigenvalue terms
  logic [SumW-1:0] diff;
  logic [SW-1:0]   s_sum, two_t, sm;
  assign diff  = (a_q >= c_q) ? a_q - c_q : c_q - a_q;
  assign s_sum = SW'(a_q) + SW'(c_q);
  assign two_t = {thr_q, 1'b0};
  assign sm    = s_sum - two_t;

  // square-root step and final rounding
  logic [RootW-1:0] t_try;
  logic [DW-1:0]    t_sq, r_sq;
  logic [RootW:0]   q_ceil;
  assign t_try  = r_q | (RootW'(1) << bit_q);
  assign t_sq   = DW'(t_try) * DW'(t_try);
  assign r_sq   = DW'(r_q) * DW'(r_q);
  assign q_ceil = (RootW + 1)'(r_q) + (RootW + 1)'(r_sq < d_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_READ;
      ST_READ: state_d = eligible ? ST_SUM : ST_IDLE;
      ST_SUM:  if (sum_k_q == 2'(WINDOW_SIZE - 1)) state_d = ST_MUL;
      ST_MUL:  state_d = ST_CMP;
      ST_CMP:  state_d = (spos_q && smsq_q > dsq_q + (bsq_q << 2)) ? ST_SQRT : ST_IDLE;
      ST_SQRT: if (bit_q == 5'd0) state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      clr_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      out_vld_q <= 1'b0;
      sum_k_q   <= '0;
      bit_q     <= '0;
      for (int i = 0; i < NWin; i++) win_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (clr_busy) clr_q <= clr_q + WW'(1);
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (state_q == ST_READ) begin
        for (int k = 0; k < WINDOW_SIZE; k++) begin
          for (int m = 0; m + 1 < WINDOW_SIZE; m++) begin
            win_q[k * WINDOW_SIZE + m] <= win_q[k * WINDOW_SIZE + m + 1];
          end
        end
        win_q[WINDOW_SIZE - 1]               <= ls_rdata[PixW-1:0];
        win_q[2 * WINDOW_SIZE - 1]           <= ls_rdata[LsW-1 -: PixW];
        win_q[WINDOW_SIZE * WINDOW_SIZE - 1] <= px_q;
        sum_k_q <= '0;
      end else if (state_q == ST_SUM) begin
        sum_k_q <= sum_k_q + 2'd1;
      end
      if (state_q == ST_CMP) begin
        bit_q <= 5'(RootW - 1);
      end else if (state_q == ST_SQRT && bit_q != 5'd0) begin
        bit_q <= bit_q - 5'd1;
      end
      if (state_q == ST_OUT && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q      <= {s_axis_tdata[GradW-1:0], s_axis_tdata[PixW-1:GradW]};
      cur_col_q <= col_q;
      cur_row_q <= row_q;
    end
    if (state_q == ST_READ) begin
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
    end else if (state_q == ST_SUM) begin
      a_q <= a_q + pa;
      b_q <= b_q + pb;
      c_q <= c_q + pc;
    end
    if (state_q == ST_MUL) begin
      dsq_q  <= DW'(diff) * DW'(diff);
      bsq_q  <= DW'(b_q) * DW'(b_q);
      smsq_q <= DW'(sm) * DW'(sm);
      s_q    <= s_sum;
      spos_q <= s_sum > two_t;
    end
    if (state_q == ST_CMP) begin
      d_q <= dsq_q + (bsq_q << 2);
      r_q <= '0;
    end
    if (state_q == ST_SQRT && t_sq <= d_q) begin
      r_q <= t_try;
    end
    if (state_q == ST_FIN) begin
      str_q <= (q_ceil <= (RootW + 1)'(s_q)) ?
               StrW'(((RootW + 1)'(s_q) - q_ceil) >> 1) : '0;
    end
    if (state_q == ST_OUT && out_free) begin
      out_row_q <= RowW'(32'(cur_row_q) - Lines);
      out_col_q <= ColW'(32'(cur_col_q) - Lines);
      out_str_q <= str_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OutDataW - RowW - ColW - StrW)'(0), out_str_q, out_col_q, out_row_q};

`ifndef SYNTHESIS
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_READ)) else $error("accept did not start a read");
  a_sqrt_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (32'(bit_q) < RootW)) else $error("root step out of range");
`endif

endmodule

`default_nettype wire

@@ sv/mecd_ram.sv @@
// ----------------------------------------------------------------------------
// mecd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mecd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
